>>> hdl/dsyn_pkg.sv
// ----------------------------------------------------------------------------
// dsyn_pkg
// shared constants, types and the quarter-wave sine table of the synthesizer
// ----------------------------------------------------------------------------
package dsyn_pkg;

    localparam int KEY_W        = 4;
    localparam int INDEX_W      = 16;
    localparam int RATE_W       = 16;
    localparam int FREQ_W       = 11;
    localparam int PROD_W       = FREQ_W + INDEX_W;     // f * n
    localparam int TBL_BITS     = 10;                   // sine table index width
    localparam int DIV_STEPS    = PROD_W + TBL_BITS;    // one quotient bit per stage
    localparam int QUARTER      = 256;
    localparam int QTR_W        = 8;
    localparam int SINE_W       = 17;                   // signed q15 with headroom
    localparam int SAMPLE_W     = 8;
    localparam int PIPE_DEPTH   = 1 + DIV_STEPS + 2;    // multiply, divide, lookup, mix

    localparam int PADDR_W      = 3;
    localparam logic [PADDR_W-1:0] ADDR_SAMPLE_RATE = 3'd0;
    localparam logic [RATE_W-1:0]  SAMPLE_RATE_RESET = 16'd5000;

    typedef logic [FREQ_W-1:0] freq_t;
    typedef freq_t freq_tbl_t [4];

    localparam freq_tbl_t ROW_FREQ = '{11'd697, 11'd770, 11'd852, 11'd941};
    localparam freq_tbl_t COL_FREQ = '{11'd1209, 11'd1336, 11'd1477, 11'd1633};

    typedef logic [14:0] qsine_t [QUARTER];

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // taylor series in q30, rounded to q15 magnitude
    function automatic logic [14:0] quarter_sine(input int unsigned m);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned q15;
        x    = (longint'(m) * HALF_PI_Q30) >> 8;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 6;   sum = sum - term;
        term = ((term * x2) >> 30) / 20;  sum = sum + term;
        term = ((term * x2) >> 30) / 42;  sum = sum - term;
        term = ((term * x2) >> 30) / 72;  sum = sum + term;
        term = ((term * x2) >> 30) / 110; sum = sum - term;
        term = ((term * x2) >> 30) / 156; sum = sum + term;
        term = ((term * x2) >> 30) / 210; sum = sum - term;
        q15 = (sum + 64'd16384) >> 15;
        if (q15 > 64'd32767)
        begin
            q15 = 64'd32767;
        end
        return q15[14:0];
    endfunction

    function automatic qsine_t build_qsine();
        qsine_t t;
        for (int k = 0; k < QUARTER; k++)
        begin
            t[k] = quarter_sine(k);
        end
        return t;
    endfunction

    localparam qsine_t QSINE_TABLE = build_qsine();

endpackage

>>> hdl/dtmf_sample_synthesizer_core.sv
// ----------------------------------------------------------------------------
// dtmf_sample_synthesizer_core
// keypad dual-tone sample generator with pipelined phase division
// ----------------------------------------------------------------------------
//  channel  | direction | signals
//  ---------+-----------+-------------------------------------------
//  in       | sink      | in_valid, in_ready, tone_key, sample_index
//  out      | source    | out_valid, out_ready, sample_code
//  config   | apb slave | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
//  one beat enters per cycle while in_ready is high; the PIPE_DEPTH stages are:
//  multiply, 37 long-division stages, sine lookup, mix/output register
//  the division stages set the depth, one quotient bit per stage
//  the whole pipeline advances together; a stalled output freezes every stage
//  rst_n clears the valid bits and loads sample_rate with 5000
// ----------------------------------------------------------------------------
module dtmf_sample_synthesizer_core
    import dsyn_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [KEY_W-1:0]    tone_key,
    input  logic [INDEX_W-1:0]  sample_index,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SAMPLE_W-1:0] sample_code,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [RATE_W-1:0]     rate_reg;
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    logic                  adv;
    logic [TBL_BITS-1:0]   index_col;
    logic [TBL_BITS-1:0]   index_row;

    // config register, written on the apb access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= SAMPLE_RATE_RESET;
        end
        else if (psel && penable && pwrite && (paddr == ADDR_SAMPLE_RATE))
        begin
            rate_reg <= pwdata[RATE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_SAMPLE_RATE) ? {16'd0, rate_reg} : 32'd0;

    // pipeline moves when the output slot is free or being drained
    assign adv      = !valid_reg[PIPE_DEPTH-1] || out_ready;
    assign in_ready = adv;

    assign valid_next = {valid_reg[PIPE_DEPTH-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    // column tone lane
    dsyn_phase u_phase_col (
        .clk          (clk),
        .adv          (adv),
        .freq         (COL_FREQ[tone_key[1:0]]),
        .sample_index (sample_index),
        .sample_rate  (rate_reg),
        .table_index  (index_col)
    );

    // row tone lane
    dsyn_phase u_phase_row (
        .clk          (clk),
        .adv          (adv),
        .freq         (ROW_FREQ[tone_key[3:2]]),
        .sample_index (sample_index),
        .sample_rate  (rate_reg),
        .table_index  (index_row)
    );

    // lookup and mix, last stage is the output register
    dsyn_mix u_mix (
        .clk         (clk),
        .adv         (adv),
        .index_a     (index_col),
        .index_b     (index_row),
        .sample_code (sample_code)
    );

    assign out_valid = valid_reg[PIPE_DEPTH-1];

endmodule

>>> hdl/dsyn_phase.sv
// ----------------------------------------------------------------------------
// dsyn_phase
// table index of one tone: multiply, then bit-per-stage long division
// ----------------------------------------------------------------------------
module dsyn_phase
    import dsyn_pkg::*;
(
    input  logic                clk,
    input  logic                adv,
    input  logic [FREQ_W-1:0]   freq,
    input  logic [INDEX_W-1:0]  sample_index,
    input  logic [RATE_W-1:0]   sample_rate,
    output logic [TBL_BITS-1:0] table_index
);

    logic [PROD_W-1:0]   prod_reg [DIV_STEPS+1];
    logic [RATE_W-1:0]   rem_reg  [DIV_STEPS+1];
    logic [TBL_BITS-1:0] quo_reg  [DIV_STEPS+1];

    // multiply stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg[0] <= PROD_W'(freq) * PROD_W'(sample_index);
            rem_reg[0]  <= '0;
            quo_reg[0]  <= '0;
        end
    end

    // one restoring division step per stage over (f*n) << TBL_BITS
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic            dbit;
        logic [RATE_W:0] trial;
        logic [RATE_W:0] diff;
        logic            take;
        logic [RATE_W-1:0] rem_next;
        logic [TBL_BITS-1:0] quo_next;

        if (k < PROD_W)
        begin : g_bit
            assign dbit = prod_reg[k][PROD_W-1-k];
        end
        else
        begin : g_zero
            assign dbit = 1'b0;
        end

        always_comb
        begin
            trial    = {rem_reg[k], dbit};
            diff     = trial - {1'b0, sample_rate};
            take     = (trial >= {1'b0, sample_rate});
            rem_next = take ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
            quo_next = {quo_reg[k][TBL_BITS-2:0], take};
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                prod_reg[k+1] <= prod_reg[k];
                rem_reg[k+1]  <= rem_next;
                quo_reg[k+1]  <= quo_next;
            end
        end
    end

    // zero rate: phase taken as zero
    assign table_index = (sample_rate == '0) ? '0 : quo_reg[DIV_STEPS];

endmodule

>>> hdl/dsyn_mix.sv
// ----------------------------------------------------------------------------
// dsyn_mix
// sine lookup of both tones, then sum, scale and offset to the 8-bit code
// ----------------------------------------------------------------------------
module dsyn_mix
    import dsyn_pkg::*;
(
    input  logic                clk,
    input  logic                adv,
    input  logic [TBL_BITS-1:0] index_a,
    input  logic [TBL_BITS-1:0] index_b,
    output logic [SAMPLE_W-1:0] sample_code
);

    function automatic logic signed [SINE_W-1:0] sine_of(input logic [TBL_BITS-1:0] idx);
        logic [QTR_W:0]  m;
        logic [14:0]     mag;
        logic signed [SINE_W-1:0] v;
        m   = idx[QTR_W] ? ((QTR_W+1)'(QUARTER) - {1'b0, idx[QTR_W-1:0]})
                         : {1'b0, idx[QTR_W-1:0]};
        mag = m[QTR_W] ? 15'h7fff : QSINE_TABLE[m[QTR_W-1:0]];
        v   = $signed({2'b00, mag});
        return idx[QTR_W+1] ? -v : v;
    endfunction

    logic signed [SINE_W-1:0] sa_reg;
    logic signed [SINE_W-1:0] sb_reg;
    logic [SAMPLE_W-1:0]      code_reg;
    logic [SAMPLE_W-1:0]      code_next;
    logic signed [SINE_W+1:0] total;
    logic [SINE_W-1:0]        biased;
    logic [SINE_W+8:0]        level;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sa_reg <= sine_of(index_a);
            sb_reg <= sine_of(index_b);
        end
    end

    always_comb
    begin
        total     = (SINE_W+2)'(sa_reg) + (SINE_W+2)'(sb_reg) + (SINE_W+2)'(65536);
        biased    = total[SINE_W-1:0];
        level     = ((SINE_W+9)'(biased) * (SINE_W+9)'(255) + (SINE_W+9)'(65536)) >> 17;
        code_next = level[SAMPLE_W-1:0] - SAMPLE_W'(127);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            code_reg <= code_next;
        end
    end

    assign sample_code = code_reg;

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// checks the dual-tone sample synthesizer: directed keys and indexes, several
// sample rates including zero and the extremes, then random beats with random
// gaps and stalls on both sides; every sample is predicted and compared in order
// ----------------------------------------------------------------------------
module tb;
    import dsyn_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [KEY_W-1:0]    tone_key;
    logic [INDEX_W-1:0]  sample_index;
    logic                out_valid;
    logic                out_ready;
    logic [SAMPLE_W-1:0] sample_code;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    localparam int LATENCY = PIPE_DEPTH;

    // predictor state: full sine table and current rate
    int                  sine_lut [1024];
    logic [RATE_W-1:0]   rate_now;
    logic [SAMPLE_W-1:0] samples_due [$];
    int                  mismatches;
    int                  hold_cycles;   // long receiver hold-off request

    dtmf_sample_synthesizer_core uut (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // taylor quarter-wave sine in q30, rounded to q15, as the table is specified
    function automatic int taylor_q15(input int unsigned m);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned q;
        x    = (longint'(m) * 64'd1686629713) >> 8;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int i = 1; i <= 7; i++)
        begin
            term = ((term * x2) >> 30) / longint'((2 * i) * (2 * i + 1));
            if (i % 2 == 1)
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        q = (sum + 64'd16384) >> 15;
        if (q > 64'd32767)
        begin
            q = 64'd32767;
        end
        return int'(q);
    endfunction

    function automatic int tone_level(input int unsigned f, input logic [15:0] n);
        longint unsigned phase;
        if (rate_now == 0)
        begin
            return sine_lut[0];
        end
        phase = ((longint'(f) * n) % rate_now);
        phase = (phase << 16) / rate_now;
        return sine_lut[(phase >> 6) & 1023];
    endfunction

    function automatic logic [SAMPLE_W-1:0] dual_tone_sample(input logic [3:0] key,
                                                             input logic [15:0] n);
        int unsigned col_f [4];
        int unsigned row_f [4];
        int          sa;
        int          sb;
        logic [31:0] level;
        col_f = '{1209, 1336, 1477, 1633};
        row_f = '{697, 770, 852, 941};
        sa    = tone_level(col_f[key[1:0]], n);
        sb    = tone_level(row_f[key[3:2]], n);
        level = (32'd255 * 32'(sa + sb + 65536) + 32'd65536) >> 17;
        return SAMPLE_W'(level - 32'd127);
    endfunction

    task automatic report_mismatch(input string what);
        $display("error: %s", what);
        mismatches++;
    endtask

    // sender side: one beat, optional random gap before it
    task automatic send_sample(input logic [3:0] key, input logic [15:0] n);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
        begin
            gap = 0;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        tone_key     <= key;
        sample_index <= n;
        samples_due.push_back(dual_tone_sample(key, n));
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
    endtask

    // wait until the pipeline has drained
    task automatic drain();
        in_valid <= 1'b0;
        while (samples_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_rate(input logic [RATE_W-1:0] value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_SAMPLE_RATE;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        rate_now  = value;
    endtask

    // every key at one extreme of the index: even keys at zero, odd keys at the top
    task automatic test_directed();
        for (int k = 0; k < 16; k++)
        begin
            send_sample(4'(k), (k % 2 == 0) ? 16'h0000 : 16'hffff);
        end
        send_sample(4'h5, 16'h5555);
        send_sample(4'ha, 16'haaaa);
        send_sample(4'hf, 16'd4999);
        send_sample(4'h0, 16'd5000);
    endtask

    // zero rate and the extreme rates
    task automatic test_rates();
        logic [RATE_W-1:0] rates [4];
        rates = '{16'd0, 16'd1, 16'hffff, 16'd8000};
        foreach (rates[i])
        begin
            write_rate(rates[i]);
            for (int j = 0; j < 6; j++)
            begin
                send_sample(4'($urandom), 16'($urandom));
            end
        end
    endtask

    task automatic test_random();
        for (int p = 0; p < 5; p++)
        begin
            write_rate((p == 0) ? SAMPLE_RATE_RESET : 16'($urandom_range(1, 65535)));
            for (int i = 0; i < 240; i++)
            begin
                send_sample(4'($urandom), 16'($urandom));
            end
        end
    endtask

    // receiver holds off while the sender keeps offering, filling the pipe
    task automatic test_backpressure();
        hold_cycles = 200;
        for (int i = 0; i < 80; i++)
        begin
            send_sample(4'($urandom), 16'($urandom));
        end
    endtask

    // receiver: random stalls, plus the long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready   <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            out_ready <= ($urandom_range(0, 1) == 0);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // checker: compare each accepted sample with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (samples_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected sample %0d", sample_code));
            end
            else
            begin
                if (sample_code !== samples_due[0])
                begin
                    report_mismatch($sformatf("sample_code %0d, predicted %0d",
                                              sample_code, samples_due[0]));
                end
                void'(samples_due.pop_front());
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        tone_key     = '0;
        sample_index = '0;
        out_ready    = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        mismatches   = 0;
        hold_cycles  = 0;
        rate_now     = SAMPLE_RATE_RESET;
        // build the full wave by quadrant mirroring
        for (int k = 0; k < 1024; k++)
        begin
            int q;
            int r;
            int v;
            q = k / 256;
            r = k % 256;
            v = taylor_q15((q % 2 == 1) ? 256 - r : r);
            sine_lut[k] = (q >= 2) ? -v : v;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_rates();
        test_random();
        test_backpressure();
        drain();

        if (mismatches == 0 && samples_due.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
hdl/dsyn_pkg.sv
hdl/dsyn_phase.sv
hdl/dsyn_mix.sv
hdl/dtmf_sample_synthesizer_core.sv
tb/tb.sv
